/* rtl/ethgc_pkg.sv */
`default_nettype none
package ethgc_pkg;

   localparam logic DIR_G2E = 1'b0;
   localparam logic DIR_E2G = 1'b1;

   localparam logic [11:0] GREG_LO = 12'd1901;
   localparam logic [11:0] GREG_HI = 12'd2099;
   localparam logic [11:0] ETH_LO  = 12'd1893;
   localparam logic [11:0] ETH_HI  = 12'd2092;
   localparam logic [11:0] GREG_NONLEAP_LO = 12'd1900;
   localparam logic [11:0] ETH_YEAR_OFFSET = 12'd7;

   localparam logic [4:0] ETH_MONTH_DAYS = 5'd30;
   localparam logic [3:0] PAGUME         = 4'd13;
   localparam logic [8:0] NEW_YEAR_DOY   = 9'd253;
   localparam logic [8:0] PRIOR_YEAR_ADJ = 9'd112;

   typedef struct packed {
      logic        req_type;
      logic [11:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic        date_valid;
   } rsp_payload_type;

   function automatic logic [8:0] before_month(input logic [3:0] m, input logic leap);
      logic [8:0] base;
      unique case (m)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && (m > 4'd2)) ? 1 : 0);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:        len = 5'd31;
         default:                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

/* rtl/ethiopian_gregorian_date_convert.sv */
`default_nettype none
// Converts one date per beat between the Gregorian and Ethiopian calendars
// (req_type 0: Gregorian to Ethiopian, 1: Ethiopian to Gregorian). The
// Gregorian side must lie in 1901..2099; an invalid or out-of-range date
// returns date_valid 0 with a zero date. Four register stages (check, day
// offset, reciprocal multiply or year rollover, month split into the output
// register) sustain a rate of one beat per cycle while rsp_ready stays high;
// each stage holds under back-pressure and takes a new beat as soon as the
// stage after it frees up.
module ethiopian_gregorian_date_convert
   import ethgc_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  wire             rsp_ready,
   output rsp_payload_type rsp_data
);

   logic en_a, en_b, en_c, en_o;

   // stage a: check input, base Gregorian year and leap flags
   logic        va_ff;
   logic        dir_a_ff, dir_a_in;
   logic        ok_a_ff, ok_a_in;
   logic [11:0] g_a_ff, g_a_in;
   logic [3:0]  m_a_ff;
   logic [4:0]  d_a_ff;
   logic        lcur_a_ff, lcur_a_in;
   logic        lnext_a_ff, lnext_a_in;

   // stage b: day offset
   logic        vb_ff;
   logic        dir_b_ff;
   logic        ok_b_ff;
   logic [11:0] yr_b_ff, yr_b_in;
   logic [9:0]  val_b_ff, val_b_in;
   logic        lcur_b_ff;

   // stage c: month quotient estimate or year rollover
   logic        vc_ff;
   logic        dir_c_ff;
   logic        ok_c_ff, ok_c_in;
   logic [11:0] yr_c_ff, yr_c_in;
   logic [9:0]  val_c_ff, val_c_in;
   logic [3:0]  q_c_ff, q_c_in;
   logic        leap_c_ff, leap_c_in;

   // output register
   logic            vo_ff;
   rsp_payload_type rsp_ff, rsp_in;

   assign en_o      = !vo_ff || rsp_ready;
   assign en_c      = !vc_ff || en_o;
   assign en_b      = !vb_ff || en_c;
   assign en_a      = !va_ff || en_b;
   assign req_ready = en_a;
   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [11:0] y;
      logic [3:0]  m;
      logic [4:0]  d;
      logic        g_ok, e_ok;
      logic [4:0]  pag_len;
      y = req_data.in_year;
      m = req_data.in_month;
      d = req_data.in_day;
      g_ok = (y >= GREG_LO) && (y <= GREG_HI) && (m >= 4'd1) && (m <= 4'd12)
             && (d >= 5'd1) && (d <= month_len(m, y[1:0] == 2'd0));
      pag_len = (y[1:0] == 2'd3) ? 5'd6 : 5'd5;
      e_ok = (y >= ETH_LO) && (y <= ETH_HI) && (m >= 4'd1) && (m <= PAGUME)
             && (d >= 5'd1) && (d <= ETH_MONTH_DAYS)
             && !((m == PAGUME) && (d > pag_len));
      dir_a_in   = req_data.req_type;
      ok_a_in    = (dir_a_in == DIR_E2G) ? e_ok : g_ok;
      g_a_in     = (dir_a_in == DIR_E2G) ? y + ETH_YEAR_OFFSET : y;
      lcur_a_in  = (g_a_in[1:0] == 2'd0) && (g_a_in != GREG_NONLEAP_LO);
      lnext_a_in = (g_a_in[1:0] == 2'd3) && (g_a_in != GREG_HI);
   end

   always_comb begin
      logic [8:0] ny, doy, off;
      logic       ge;
      ny  = NEW_YEAR_DOY + 9'(lcur_a_ff) + 9'(lnext_a_ff);
      doy = before_month(m_a_ff, lcur_a_ff) + 9'(d_a_ff) - 9'd1;
      ge  = doy >= ny;
      off = ge ? doy - ny : doy + PRIOR_YEAR_ADJ - 9'(lcur_a_ff);
      if (dir_a_ff == DIR_E2G) begin
         yr_b_in  = g_a_ff;
         val_b_in = 10'(ny) + 10'(m_a_ff - 4'd1) * 10'(ETH_MONTH_DAYS)
                    + 10'(d_a_ff) - 10'd1;
      end else begin
         yr_b_in  = ge ? g_a_ff - ETH_YEAR_OFFSET : g_a_ff - ETH_YEAR_OFFSET - 12'd1;
         val_b_in = 10'(off);
      end
   end

   always_comb begin
      logic [14:0] prod;
      logic [9:0]  ylen;
      logic        roll;
      prod = 15'(val_b_ff) * 15'd17;
      ylen = 10'd365 + 10'(lcur_b_ff);
      roll = val_b_ff >= ylen;
      q_c_in = prod[12:9];
      if (dir_b_ff == DIR_E2G) begin
         yr_c_in  = roll ? yr_b_ff + 12'd1 : yr_b_ff;
         val_c_in = roll ? val_b_ff - ylen : val_b_ff;
         ok_c_in  = ok_b_ff && (yr_c_in >= GREG_LO) && (yr_c_in <= GREG_HI);
      end else begin
         yr_c_in  = yr_b_ff;
         val_c_in = val_b_ff;
         ok_c_in  = ok_b_ff;
      end
      leap_c_in = yr_c_in[1:0] == 2'd0;
   end

   always_comb begin
      logic [9:0] r0;
      logic [3:0] q, gm;
      logic [9:0] r;
      logic [8:0] doy, dd;
      r0 = val_c_ff - 10'(q_c_ff) * 10'(ETH_MONTH_DAYS);
      if (r0 >= 10'(ETH_MONTH_DAYS)) begin
         q = q_c_ff + 4'd1;
         r = r0 - 10'(ETH_MONTH_DAYS);
      end else begin
         q = q_c_ff;
         r = r0;
      end
      doy = val_c_ff[8:0];
      gm  = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         if (doy >= before_month(4'(k), leap_c_ff)) gm = 4'(k);
      end
      dd = doy - before_month(gm, leap_c_ff) + 9'd1;
      rsp_in = '0;
      if (ok_c_ff) begin
         rsp_in.out_year   = yr_c_ff;
         rsp_in.date_valid = 1'b1;
         if (dir_c_ff == DIR_E2G) begin
            rsp_in.out_month = gm;
            rsp_in.out_day   = dd[4:0];
         end else begin
            rsp_in.out_month = q + 4'd1;
            rsp_in.out_day   = r[4:0] + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= req_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
         if (en_o) vo_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         dir_a_ff   <= dir_a_in;
         ok_a_ff    <= ok_a_in;
         g_a_ff     <= g_a_in;
         m_a_ff     <= req_data.in_month;
         d_a_ff     <= req_data.in_day;
         lcur_a_ff  <= lcur_a_in;
         lnext_a_ff <= lnext_a_in;
      end
      if (en_b) begin
         dir_b_ff  <= dir_a_ff;
         ok_b_ff   <= ok_a_ff;
         yr_b_ff   <= yr_b_in;
         val_b_ff  <= val_b_in;
         lcur_b_ff <= lcur_a_ff;
      end
      if (en_c) begin
         dir_c_ff  <= dir_b_ff;
         ok_c_ff   <= ok_c_in;
         yr_c_ff   <= yr_c_in;
         val_c_ff  <= val_c_in;
         q_c_ff    <= q_c_in;
         leap_c_ff <= leap_c_in;
      end
      if (en_o) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
